[rtl/rtu_fc_pkg.sv]
// Shared types, constants and the CRC-16 byte step for the RTU frame checker.
// Used by every module in rtl/; depends on nothing else.
package rtu_fc_pkg;

    localparam int unsigned BUF_DEPTH_DEFAULT = 256;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  FC_EXC_FLAG  = 8'h80;
    localparam logic [7:0]  EXC_ILLEGAL  = 8'h01;
    localparam logic [7:0]  DEV_ADDR_RST = 8'h01;

    // configuration register indexes
    localparam logic [7:0] REG_DEVICE_ADDRESS = 8'd0;
    localparam logic [7:0] REG_FUNCTION_MASK  = 8'd1;

    // input kinds carried on s_tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_GAP  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CRC     = 3'd1,
        ST_ADDR    = 3'd2,
        ST_OVF     = 3'd3,
        ST_ILLEGAL = 3'd4
    } status_t;

    // outcome of one finished frame, handed to the reply stage
    typedef struct packed {
        status_t    status;
        logic [8:0] frame_length;
        logic [7:0] function_code;
    } frame_res_t;

    // reflected CRC-16 over one byte; unrolls to an XOR network
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/rtu_fc_frame.sv]
// Frame accumulator: byte count, address/function capture, delayed CRC-16,
// and the frame-end checks. Depends on rtu_fc_pkg.
module rtu_fc_frame #(
    parameter int unsigned BUF_DEPTH = rtu_fc_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_fire,
    input  logic                    in_cmd,
    input  logic [7:0]              in_byte,
    input  logic [7:0]              device_address,
    input  logic [63:0]             function_mask,
    output logic                    end_fire,
    output rtu_fc_pkg::frame_res_t  frame_res
);

    logic        receiving_reg, receiving_next;
    logic [8:0]  count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  rb0_reg, rb0_next;
    logic [7:0]  rb1_reg, rb1_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  fc_reg, fc_next;

    logic        full;
    logic        fc_supported;
    logic [15:0] got_crc;

    assign full         = (count_reg >= 9'(BUF_DEPTH));
    assign got_crc      = {rb1_reg, rb0_reg};
    assign fc_supported = (fc_reg[7:6] == 2'b00) && function_mask[fc_reg[5:0]];
    assign end_fire     = in_fire && (in_cmd == rtu_fc_pkg::CMD_GAP) && receiving_reg;

    always_comb begin
        frame_res.frame_length  = count_reg;
        frame_res.function_code = fc_reg;
        if (ovf_reg) begin
            frame_res.status = rtu_fc_pkg::ST_OVF;
        end else if (addr_reg != device_address) begin
            frame_res.status = rtu_fc_pkg::ST_ADDR;
        end else if (count_reg < 9'd3 || got_crc != crc_reg) begin
            frame_res.status = rtu_fc_pkg::ST_CRC;
        end else if (fc_supported) begin
            frame_res.status = rtu_fc_pkg::ST_OK;
        end else begin
            frame_res.status = rtu_fc_pkg::ST_ILLEGAL;
        end
    end

    always_comb begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        crc_next       = crc_reg;
        rb0_next       = rb0_reg;
        rb1_next       = rb1_reg;
        addr_next      = addr_reg;
        fc_next        = fc_reg;
        if (in_fire && in_cmd == rtu_fc_pkg::CMD_BYTE) begin
            receiving_next = 1'b1;
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                // CRC trails the input by two bytes so the received CRC stays out
                if (count_reg >= 9'd2) begin
                    crc_next = rtu_fc_pkg::crc_feed(crc_reg, rb0_reg);
                end
                rb0_next = rb1_reg;
                rb1_next = in_byte;
                if (count_reg == 9'd0) begin
                    addr_next = in_byte;
                end else if (count_reg == 9'd1) begin
                    fc_next = in_byte;
                end
                count_next = count_reg + 9'd1;
            end
        end else if (in_fire) begin
            receiving_next = 1'b0;
            count_next     = '0;
            ovf_next       = 1'b0;
            crc_next       = rtu_fc_pkg::CRC_INIT;
            rb0_next       = '0;
            rb1_next       = '0;
            addr_next      = '0;
            fc_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            crc_reg       <= rtu_fc_pkg::CRC_INIT;
            rb0_reg       <= '0;
            rb1_reg       <= '0;
            addr_reg      <= '0;
            fc_reg        <= '0;
        end else begin
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            crc_reg       <= crc_next;
            rb0_reg       <= rb0_next;
            rb1_reg       <= rb1_next;
            addr_reg      <= addr_next;
            fc_reg        <= fc_next;
        end
    end

endmodule

[rtl/rtu_fc_reply.sv]
// Result register and reply sequencer: one result for a normal outcome,
// five for an exception reply whose CRC is built one byte per beat.
// Depends on rtu_fc_pkg.
module rtu_fc_reply (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  rtu_fc_pkg::frame_res_t  frame_res,
    input  logic [7:0]              device_address,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic                    out_last,
    output rtu_fc_pkg::status_t     out_status,
    output logic [8:0]              out_length,
    output logic [7:0]              out_fc,
    output logic                    out_tx_valid,
    output logic [7:0]              out_tx_byte
);

    logic                busy_reg, busy_next;
    logic [2:0]          idx_reg, idx_next;
    rtu_fc_pkg::status_t st_reg, st_next;
    logic [8:0]          len_reg, len_next;
    logic [7:0]          fc_reg, fc_next;
    logic [7:0]          addr_reg, addr_next;
    logic [15:0]         crc_reg, crc_next;

    logic exc;
    logic beat;

    assign exc          = (st_reg == rtu_fc_pkg::ST_ILLEGAL);
    assign out_valid    = busy_reg;
    assign out_status   = st_reg;
    assign out_length   = len_reg;
    assign out_fc       = fc_reg;
    assign out_tx_valid = exc;
    assign out_last     = !exc || (idx_reg == 3'd4);
    assign beat         = busy_reg && out_ready;

    always_comb begin
        out_tx_byte = '0;
        if (exc) begin
            case (idx_reg)
                3'd0:    out_tx_byte = addr_reg;
                3'd1:    out_tx_byte = fc_reg | rtu_fc_pkg::FC_EXC_FLAG;
                3'd2:    out_tx_byte = rtu_fc_pkg::EXC_ILLEGAL;
                3'd3:    out_tx_byte = crc_reg[7:0];
                3'd4:    out_tx_byte = crc_reg[15:8];
                default: out_tx_byte = '0;
            endcase
        end
    end

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        st_next   = st_reg;
        len_next  = len_reg;
        fc_next   = fc_reg;
        addr_next = addr_reg;
        crc_next  = crc_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
            st_next   = frame_res.status;
            len_next  = frame_res.frame_length;
            fc_next   = frame_res.function_code;
            addr_next = device_address;
            crc_next  = rtu_fc_pkg::CRC_INIT;
        end else if (beat) begin
            if (out_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
                // reply CRC covers the three header bytes
                if (idx_reg < 3'd3) begin
                    crc_next = rtu_fc_pkg::crc_feed(crc_reg, out_tx_byte);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            st_reg   <= rtu_fc_pkg::ST_OK;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            st_reg   <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        fc_reg   <= fc_next;
        addr_reg <= addr_next;
        crc_reg  <= crc_next;
    end

endmodule

[rtl/rtu_frame_checker_top.sv]
// Latency: a frame-gap request that ends a frame yields its first result on the next cycle.
// Throughput: one request per cycle; after a frame end s_tready stays low while a non-last
// result is pending (as during an exception reply) or the pending result is stalled.
// Reset: aresetn is synchronous, active low; clears frame state, sets device
// address to 1 and the function mask to 0. No clearing pass.
module rtu_frame_checker_top #(
    parameter int unsigned BUF_DEPTH = rtu_fc_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] status, [11:3] frame_length,
                                   // [19:12] function_code, [27:20] tx_byte
    output logic        m_tuser,   // [0] tx_valid
    output logic        m_tlast
);

    logic [7:0]  dev_addr_reg;
    logic [63:0] fmask_reg;

    logic                   in_fire;
    logic                   end_fire;
    rtu_fc_pkg::frame_res_t frame_res;
    rtu_fc_pkg::status_t    out_status;
    logic [8:0]             out_length;
    logic [7:0]             out_fc;
    logic [7:0]             out_tx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= rtu_fc_pkg::DEV_ADDR_RST;
            fmask_reg    <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == rtu_fc_pkg::REG_DEVICE_ADDRESS) begin
                dev_addr_reg <= cfg_wdata[7:0];
            end else if (cfg_index == rtu_fc_pkg::REG_FUNCTION_MASK) begin
                fmask_reg <= cfg_wdata;
            end
        end
    end

    // free, or the final pending result leaves this cycle
    assign s_tready = !m_tvalid || (m_tready && m_tlast);
    assign in_fire  = s_tvalid && s_tready;

    rtu_fc_frame #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_frame (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_fire        (in_fire),
        .in_cmd         (s_tuser),
        .in_byte        (s_tdata),
        .device_address (dev_addr_reg),
        .function_mask  (fmask_reg),
        .end_fire       (end_fire),
        .frame_res      (frame_res)
    );

    rtu_fc_reply u_reply (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (end_fire),
        .frame_res      (frame_res),
        .device_address (dev_addr_reg),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_last       (m_tlast),
        .out_status     (out_status),
        .out_length     (out_length),
        .out_fc         (out_fc),
        .out_tx_valid   (m_tuser),
        .out_tx_byte    (out_tx_byte)
    );

    assign m_tdata = {4'h0, out_tx_byte, out_fc, out_length, out_status};

`ifndef SYNTHESIS
    // reply bytes appear only with the illegal-function status
    a_txv_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[2:0] == rtu_fc_pkg::ST_ILLEGAL)
        else $error("reply byte without illegal-function status");

    // a normal outcome is a single result
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("normal outcome not marked last");

    // after the last result drains with no new frame end, output goes idle
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast && !end_fire |=> !m_tvalid)
        else $error("result repeated after last beat");

    // a frame end always produces a result next cycle
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        end_fire |=> m_tvalid)
        else $error("frame end lost");
`endif

endmodule
